// ===== design/shs_pkg.sv =====
package shs_pkg;

   localparam int TICKS_PER_MS = 1000;
   localparam int DIV_WIDTH = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;

   localparam int HALF_WIDTH = 19;
   localparam int STEPS_WIDTH = 10;
   localparam int BTO_WIDTH = 12;
   localparam int ATO_WIDTH = 16;
   localparam int PAUSE_WIDTH = 10;
   localparam int MS_WIDTH = 16;
   localparam int CSR_DATA_WIDTH = 19;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [HALF_WIDTH-1:0] MIN_HALF_PERIOD = HALF_WIDTH'(50);
   localparam logic [STEPS_WIDTH-1:0] STEP_COUNT_MAX = '1;
   localparam logic [MS_WIDTH-1:0] MS_COUNT_MAX = '1;

   localparam logic [HALF_WIDTH-1:0] HALF_PERIOD_RESET = HALF_WIDTH'(1000);
   localparam logic [STEPS_WIDTH-1:0] INITIAL_BACKOFF_RESET = STEPS_WIDTH'(200);
   localparam logic [STEPS_WIDTH-1:0] FINAL_BACKOFF_RESET = STEPS_WIDTH'(100);
   localparam logic [BTO_WIDTH-1:0] BACKOFF_TIMEOUT_RESET = BTO_WIDTH'(300);
   localparam logic [ATO_WIDTH-1:0] APPROACH_TIMEOUT_RESET = ATO_WIDTH'(3000);
   localparam logic [PAUSE_WIDTH-1:0] PAUSE_RESET = PAUSE_WIDTH'(30);
   localparam logic [PAUSE_WIDTH-1:0] START_PAUSE_RESET = PAUSE_WIDTH'(20);

   typedef enum logic [3:0] {
      PHASE_IDLE        = 4'd0,
      PHASE_START_PAUSE = 4'd1,
      PHASE_BACKOFF     = 4'd2,
      PHASE_PAUSE       = 4'd3,
      PHASE_APPROACH    = 4'd4,
      PHASE_FINAL_PAUSE = 4'd5,
      PHASE_FINAL_BACK  = 4'd6,
      PHASE_DONE        = 4'd7,
      PHASE_FAILED      = 4'd8
   } phase_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HALF_PERIOD      = 3'd0,
      CSR_INITIAL_BACKOFF  = 3'd1,
      CSR_FINAL_BACKOFF    = 3'd2,
      CSR_BACKOFF_TIMEOUT  = 3'd3,
      CSR_APPROACH_TIMEOUT = 3'd4,
      CSR_PAUSE            = 3'd5,
      CSR_START_PAUSE      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [HALF_WIDTH-1:0]  half_period_us;
      logic [STEPS_WIDTH-1:0] initial_backoff_steps;
      logic [STEPS_WIDTH-1:0] final_backoff_steps;
      logic [BTO_WIDTH-1:0]   backoff_timeout_ms;
      logic [ATO_WIDTH-1:0]   approach_timeout_ms;
      logic [PAUSE_WIDTH-1:0] pause_ms;
      logic [PAUSE_WIDTH-1:0] start_pause_ms;
   } cfg_type;

   typedef struct packed {
      logic      step_level;
      logic      dir_toward;
      logic [3:0] phase;
      logic      done_pulse;
      logic      fail_pulse;
      logic      zero_encoder;
   } result_type;

endpackage

// ===== design/shs_if.sv =====
interface shs_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic switch_pressed;

   modport source (output valid, output start_req, output switch_pressed, input ready);
   modport sink (input valid, input start_req, input switch_pressed, output ready);
endinterface

interface shs_rsp_if;
   logic       valid;
   logic       ready;
   logic       step_level;
   logic       dir_toward;
   logic [3:0] phase;
   logic       done_pulse;
   logic       fail_pulse;
   logic       zero_encoder;

   modport source (output valid, output step_level, output dir_toward, output phase,
                   output done_pulse, output fail_pulse, output zero_encoder, input ready);
   modport sink (input valid, input step_level, input dir_toward, input phase,
                 input done_pulse, input fail_pulse, input zero_encoder, output ready);
endinterface

// ===== design/shs_csr.sv =====
module shs_csr
   import shs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HALF_PERIOD:      cfg_in.half_period_us = csr_wdata[HALF_WIDTH-1:0];
            CSR_INITIAL_BACKOFF:  cfg_in.initial_backoff_steps = csr_wdata[STEPS_WIDTH-1:0];
            CSR_FINAL_BACKOFF:    cfg_in.final_backoff_steps = csr_wdata[STEPS_WIDTH-1:0];
            CSR_BACKOFF_TIMEOUT:  cfg_in.backoff_timeout_ms = csr_wdata[BTO_WIDTH-1:0];
            CSR_APPROACH_TIMEOUT: cfg_in.approach_timeout_ms = csr_wdata[ATO_WIDTH-1:0];
            CSR_PAUSE:            cfg_in.pause_ms = csr_wdata[PAUSE_WIDTH-1:0];
            CSR_START_PAUSE:      cfg_in.start_pause_ms = csr_wdata[PAUSE_WIDTH-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_us <= HALF_PERIOD_RESET;
         cfg_ff.initial_backoff_steps <= INITIAL_BACKOFF_RESET;
         cfg_ff.final_backoff_steps <= FINAL_BACKOFF_RESET;
         cfg_ff.backoff_timeout_ms <= BACKOFF_TIMEOUT_RESET;
         cfg_ff.approach_timeout_ms <= APPROACH_TIMEOUT_RESET;
         cfg_ff.pause_ms <= PAUSE_RESET;
         cfg_ff.start_pause_ms <= START_PAUSE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/shs_engine.sv =====
module shs_engine
   import shs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       start_req,
   input  logic       switch_pressed,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type              phase_ff, phase_in, next_phase;
   logic [STEPS_WIDTH-1:0] edge_ff, edge_in;
   logic [MS_WIDTH-1:0]    ms_ff, ms_in;
   logic [DIV_WIDTH-1:0]   div_ff, div_in;
   logic [HALF_WIDTH-1:0]  timer_ff, timer_in;
   logic                   pulse_ff, pulse_in;
   logic                   dir_ff, dir_in;

   logic                   ms_tick;
   logic                   done;
   logic                   fail;
   logic                   bto_hit;
   logic                   step_end_initial;
   logic                   step_end_final;
   logic [HALF_WIDTH-1:0]  half_period;
   logic [HALF_WIDTH:0]    timer_next;

   always_comb begin
      ms_tick = (div_ff == DIV_WIDTH'(TICKS_PER_MS - 1));
      bto_hit = ms_tick && (ms_ff >= MS_WIDTH'(cfg.backoff_timeout_ms));
      step_end_initial = (edge_ff >= cfg.initial_backoff_steps);
      step_end_final = (edge_ff >= cfg.final_backoff_steps);
      half_period = (cfg.half_period_us < MIN_HALF_PERIOD) ? MIN_HALF_PERIOD
                                                           : cfg.half_period_us;
      timer_next = {1'b0, timer_ff} + (HALF_WIDTH + 1)'(1);
      done = 1'b0;
      fail = 1'b0;
      next_phase = phase_ff;

      case (phase_ff)
         PHASE_IDLE, PHASE_DONE, PHASE_FAILED: begin
            if (start_req) next_phase = PHASE_START_PAUSE;
         end
         PHASE_START_PAUSE: begin
            if (ms_ff >= MS_WIDTH'(cfg.start_pause_ms)) begin
               next_phase = switch_pressed ? PHASE_BACKOFF : PHASE_APPROACH;
            end
         end
         PHASE_BACKOFF: begin
            if (step_end_initial || bto_hit) next_phase = PHASE_PAUSE;
         end
         PHASE_PAUSE: begin
            if (ms_ff >= MS_WIDTH'(cfg.pause_ms)) next_phase = PHASE_APPROACH;
         end
         PHASE_APPROACH: begin
            if (switch_pressed) begin
               next_phase = PHASE_FINAL_PAUSE;
            end else if (ms_tick && (ms_ff >= cfg.approach_timeout_ms)) begin
               next_phase = PHASE_FAILED;
               fail = 1'b1;
            end
         end
         PHASE_FINAL_PAUSE: begin
            if (ms_ff >= MS_WIDTH'(cfg.pause_ms)) next_phase = PHASE_FINAL_BACK;
         end
         PHASE_FINAL_BACK: begin
            if (step_end_final || bto_hit) begin
               next_phase = PHASE_DONE;
               done = 1'b1;
            end
         end
         default: next_phase = PHASE_IDLE;
      endcase

      phase_in = phase_ff;
      edge_in = edge_ff;
      ms_in = ms_ff;
      div_in = div_ff;
      timer_in = timer_ff;
      pulse_in = pulse_ff;
      dir_in = dir_ff;

      if (next_phase != phase_ff) begin
         phase_in = next_phase;
         edge_in = '0;
         ms_in = '0;
         div_in = '0;
         timer_in = '0;
         pulse_in = 1'b0;
         if (next_phase == PHASE_BACKOFF || next_phase == PHASE_FINAL_BACK) dir_in = 1'b0;
         if (next_phase == PHASE_APPROACH) dir_in = 1'b1;
      end else if (phase_ff inside {[PHASE_START_PAUSE:PHASE_FINAL_BACK]}) begin
         if (ms_tick) begin
            div_in = '0;
            if (ms_ff != MS_COUNT_MAX) ms_in = ms_ff + MS_WIDTH'(1);
         end else begin
            div_in = div_ff + DIV_WIDTH'(1);
         end
         if (phase_ff inside {PHASE_BACKOFF, PHASE_APPROACH, PHASE_FINAL_BACK}) begin
            if (timer_next >= {1'b0, half_period}) begin
               timer_in = '0;
               pulse_in = ~pulse_ff;
               if (!pulse_ff && edge_ff != STEP_COUNT_MAX) edge_in = edge_ff + STEPS_WIDTH'(1);
            end else begin
               timer_in = timer_next[HALF_WIDTH-1:0];
            end
         end
      end

      result.step_level = pulse_in;
      result.dir_toward = dir_in;
      result.phase = phase_in;
      result.done_pulse = done;
      result.fail_pulse = fail;
      result.zero_encoder = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         edge_ff <= '0;
         ms_ff <= '0;
         div_ff <= '0;
         timer_ff <= '0;
         pulse_ff <= 1'b0;
         dir_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         edge_ff <= edge_in;
         ms_ff <= ms_in;
         div_ff <= div_in;
         timer_ff <= timer_in;
         pulse_ff <= pulse_in;
         dir_ff <= dir_in;
      end
   end

endmodule

// ===== design/stepper_homing_sequencer.sv =====
// The response to a request is registered and presented in the cycle after the request is accepted.
// One request per cycle while the response is taken; the output register refills in the cycle it is taken.
// Rate is set by the single sequencer update between the state registers and the output register.
// Reset (synchronous, active high): phase idle, timebase and step generator cleared,
// configuration registers at their default values, no response pending.
module stepper_homing_sequencer
   import shs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   shs_req_if.sink                    req_if,
   shs_rsp_if.source                  rsp_if,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;

   shs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign advance = req_if.valid && req_if.ready;

   shs_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .start_req      (req_if.start_req),
      .switch_pressed (req_if.switch_pressed),
      .cfg            (cfg),
      .result         (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.step_level = rsp_ff.step_level;
   assign rsp_if.dir_toward = rsp_ff.dir_toward;
   assign rsp_if.phase = rsp_ff.phase;
   assign rsp_if.done_pulse = rsp_ff.done_pulse;
   assign rsp_if.fail_pulse = rsp_ff.fail_pulse;
   assign rsp_if.zero_encoder = rsp_ff.zero_encoder;

endmodule

// ===== verif/testbench.sv =====
module testbench
   import shs_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INDEX_SPARE = 3'd7;

   typedef struct packed {
      logic start_req;
      logic switch_pressed;
   } tick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   shs_req_if req_if();
   shs_rsp_if rsp_if();

   stepper_homing_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   tick_type    pending_ticks[$];
   result_type  expected_results[$];
   tick_type    drive_tick;
   bit          steady = 1'b0;
   int unsigned send_gap = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned error_count = 0;

   // sequencer image
   cfg_type                homing_cfg;
   phase_type              home_phase;
   logic [STEPS_WIDTH-1:0] step_edges;
   logic [MS_WIDTH-1:0]    phase_ms;
   logic [DIV_WIDTH-1:0]   tick_div;
   logic [HALF_WIDTH-1:0]  toggle_count;
   logic                   step_out;
   logic                   toward;
   result_type             predicted;
   result_type             want;

   function automatic int unsigned draw_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 72) return 0;
      else if (roll < 97) return $urandom_range(3, 1);
      else return $urandom_range(30, 8);
   endfunction

   function automatic cfg_type make_cfg(int unsigned half, int unsigned steps_in,
                                        int unsigned steps_out, int unsigned bto,
                                        int unsigned ato, int unsigned pause,
                                        int unsigned start_pause);
      cfg_type c;
      c.half_period_us        = HALF_WIDTH'(half);
      c.initial_backoff_steps = STEPS_WIDTH'(steps_in);
      c.final_backoff_steps   = STEPS_WIDTH'(steps_out);
      c.backoff_timeout_ms    = BTO_WIDTH'(bto);
      c.approach_timeout_ms   = ATO_WIDTH'(ato);
      c.pause_ms              = PAUSE_WIDTH'(pause);
      c.start_pause_ms        = PAUSE_WIDTH'(start_pause);
      return c;
   endfunction

   task automatic reset_homing();
      homing_cfg = make_cfg(HALF_PERIOD_RESET, INITIAL_BACKOFF_RESET, FINAL_BACKOFF_RESET,
                            BACKOFF_TIMEOUT_RESET, APPROACH_TIMEOUT_RESET, PAUSE_RESET,
                            START_PAUSE_RESET);
      home_phase   = PHASE_IDLE;
      step_edges   = '0;
      phase_ms     = '0;
      tick_div     = '0;
      toggle_count = '0;
      step_out     = 1'b0;
      toward       = 1'b0;
   endtask

   task automatic write_homing_cfg(logic [CSR_INDEX_WIDTH-1:0] idx,
                                   logic [CSR_DATA_WIDTH-1:0] value);
      case (idx)
         CSR_HALF_PERIOD:      homing_cfg.half_period_us = value[HALF_WIDTH-1:0];
         CSR_INITIAL_BACKOFF:  homing_cfg.initial_backoff_steps = value[STEPS_WIDTH-1:0];
         CSR_FINAL_BACKOFF:    homing_cfg.final_backoff_steps = value[STEPS_WIDTH-1:0];
         CSR_BACKOFF_TIMEOUT:  homing_cfg.backoff_timeout_ms = value[BTO_WIDTH-1:0];
         CSR_APPROACH_TIMEOUT: homing_cfg.approach_timeout_ms = value[ATO_WIDTH-1:0];
         CSR_PAUSE:            homing_cfg.pause_ms = value[PAUSE_WIDTH-1:0];
         CSR_START_PAUSE:      homing_cfg.start_pause_ms = value[PAUSE_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic advance_homing(input logic start, input logic pressed, output result_type r);
      phase_type             nxt;
      logic                  ms_tick;
      logic                  done;
      logic                  fail;
      logic [HALF_WIDTH-1:0] half;
      ms_tick = (int'(tick_div) + 1 >= TICKS_PER_MS);
      done = 1'b0;
      fail = 1'b0;
      nxt = home_phase;
      case (home_phase)
         PHASE_IDLE, PHASE_DONE, PHASE_FAILED: begin
            if (start) nxt = PHASE_START_PAUSE;
         end
         PHASE_START_PAUSE: begin
            if (phase_ms >= homing_cfg.start_pause_ms) begin
               if (pressed) nxt = PHASE_BACKOFF;
               else nxt = PHASE_APPROACH;
            end
         end
         PHASE_BACKOFF: begin
            if (step_edges >= homing_cfg.initial_backoff_steps ||
                (ms_tick && phase_ms >= homing_cfg.backoff_timeout_ms)) nxt = PHASE_PAUSE;
         end
         PHASE_PAUSE: begin
            if (phase_ms >= homing_cfg.pause_ms) nxt = PHASE_APPROACH;
         end
         PHASE_APPROACH: begin
            if (pressed) begin
               nxt = PHASE_FINAL_PAUSE;
            end else if (ms_tick && phase_ms >= homing_cfg.approach_timeout_ms) begin
               nxt = PHASE_FAILED;
               fail = 1'b1;
            end
         end
         PHASE_FINAL_PAUSE: begin
            if (phase_ms >= homing_cfg.pause_ms) nxt = PHASE_FINAL_BACK;
         end
         PHASE_FINAL_BACK: begin
            if (step_edges >= homing_cfg.final_backoff_steps ||
                (ms_tick && phase_ms >= homing_cfg.backoff_timeout_ms)) begin
               nxt = PHASE_DONE;
               done = 1'b1;
            end
         end
         default: nxt = PHASE_IDLE;
      endcase

      if (nxt != home_phase) begin
         home_phase   = nxt;
         phase_ms     = '0;
         tick_div     = '0;
         step_edges   = '0;
         toggle_count = '0;
         step_out     = 1'b0;
         if (nxt == PHASE_BACKOFF || nxt == PHASE_FINAL_BACK) toward = 1'b0;
         if (nxt == PHASE_APPROACH) toward = 1'b1;
      end else if (home_phase >= PHASE_START_PAUSE && home_phase <= PHASE_FINAL_BACK) begin
         if (ms_tick) begin
            tick_div = '0;
            if (phase_ms != MS_COUNT_MAX) phase_ms = phase_ms + 1'b1;
         end else begin
            tick_div = tick_div + 1'b1;
         end
         if (home_phase == PHASE_BACKOFF || home_phase == PHASE_APPROACH ||
             home_phase == PHASE_FINAL_BACK) begin
            half = (homing_cfg.half_period_us < MIN_HALF_PERIOD) ? MIN_HALF_PERIOD
                                                                 : homing_cfg.half_period_us;
            toggle_count = toggle_count + 1'b1;
            if (toggle_count >= half) begin
               toggle_count = '0;
               step_out = ~step_out;
               if (step_out && step_edges != STEP_COUNT_MAX) step_edges = step_edges + 1'b1;
            end
         end
      end

      r.step_level   = step_out;
      r.dir_toward   = toward;
      r.phase        = home_phase;
      r.done_pulse   = done;
      r.fail_pulse   = fail;
      r.zero_encoder = done;
   endtask

   task automatic check_field(string name, logic [3:0] expected, logic [3:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
         error_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_gap != 0) begin
            req_if.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_ticks.size() != 0) begin
            drive_tick = pending_ticks.pop_front();
            req_if.valid <= 1'b1;
            req_if.start_req <= drive_tick.start_req;
            req_if.switch_pressed <= drive_tick.switch_pressed;
            send_gap <= steady ? 0 : draw_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // hold ready low for the drawn stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         hold_left <= steady ? 0 : draw_gap();
      end
   end

   // monitor: check responses first, then track requests and writes
   always @(posedge clock) begin
      if (reset) begin
         reset_homing();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response with no request pending, phase %0d",
                        $time, rsp_if.phase);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("step_level", want.step_level, rsp_if.step_level);
               check_field("dir_toward", want.dir_toward, rsp_if.dir_toward);
               check_field("phase", want.phase, rsp_if.phase);
               check_field("done_pulse", want.done_pulse, rsp_if.done_pulse);
               check_field("fail_pulse", want.fail_pulse, rsp_if.fail_pulse);
               check_field("zero_encoder", want.zero_encoder, rsp_if.zero_encoder);
            end
         end
         if (req_if.valid && req_if.ready) begin
            advance_homing(req_if.start_req, req_if.switch_pressed, predicted);
            expected_results.push_back(predicted);
         end
         if (csr_we) write_homing_cfg(csr_index, csr_wdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_start(logic pressed);
      tick_type t;
      t.start_req = 1'b1;
      t.switch_pressed = pressed;
      pending_ticks.push_back(t);
   endtask

   task automatic add_ticks(int unsigned count, logic pressed, int unsigned noise_permille);
      tick_type t;
      repeat (count) begin
         t.start_req = ($urandom_range(999) < noise_permille);
         t.switch_pressed = pressed ^ ($urandom_range(999) < noise_permille);
         pending_ticks.push_back(t);
      end
   endtask

   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_if.valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value,
                            int unsigned width);
      logic [31:0] junk;
      junk = $urandom << width;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value | junk[CSR_DATA_WIDTH-1:0];
   endtask

   task automatic program_csrs(cfg_type c);
      write_csr(CSR_HALF_PERIOD, CSR_DATA_WIDTH'(c.half_period_us), HALF_WIDTH);
      write_csr(CSR_INITIAL_BACKOFF, CSR_DATA_WIDTH'(c.initial_backoff_steps), STEPS_WIDTH);
      write_csr(CSR_FINAL_BACKOFF, CSR_DATA_WIDTH'(c.final_backoff_steps), STEPS_WIDTH);
      write_csr(CSR_BACKOFF_TIMEOUT, CSR_DATA_WIDTH'(c.backoff_timeout_ms), BTO_WIDTH);
      write_csr(CSR_APPROACH_TIMEOUT, CSR_DATA_WIDTH'(c.approach_timeout_ms), ATO_WIDTH);
      write_csr(CSR_PAUSE, CSR_DATA_WIDTH'(c.pause_ms), PAUSE_WIDTH);
      write_csr(CSR_START_PAUSE, CSR_DATA_WIDTH'(c.start_pause_ms), PAUSE_WIDTH);
      write_csr(CSR_INDEX_SPARE, '0, 0);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.start_req = 1'b0;
      req_if.switch_pressed = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // idle, start, start while running under reset settings
      add_ticks(2, 1'b0, 0);
      add_ticks(2, 1'b1, 0);
      add_start(1'b1);
      add_start(1'b0);
      add_ticks(20, 1'b1, 0);
      wait_quiet();

      // short half period, zero final backoff, immediate pauses
      program_csrs(make_cfg(10, 2, 0, 1, 0, 0, 0));
      add_ticks(170, 1'b1, 0);
      add_start(1'b0);
      add_ticks(120, 1'b0, 0);
      add_ticks(30, 1'b1, 0);

      // approach runs into its timeout at the first millisecond boundary
      steady = 1'b1;
      add_start(1'b0);
      add_ticks(1003, 1'b0, 0);
      wait_quiet();
      steady = 1'b0;

      program_csrs(make_cfg(500000, 1023, 1023, 4095, 65535, 1023, 1023));
      add_start(1'b0);
      add_ticks(12, 1'b0, 300);
      wait_quiet();
      program_csrs(make_cfg(19'h7FFFF, 1023, 1023, 4095, 65535, 1023, 1023));
      add_ticks(8, 1'b0, 300);
      wait_quiet();

      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

// ===== stepper_homing_sequencer.f =====
design/shs_pkg.sv
design/shs_if.sv
design/shs_csr.sv
design/shs_engine.sv
design/stepper_homing_sequencer.sv
verif/testbench.sv
